// File: rtl/core/displacement_covariance_accumulator_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef DISPLACEMENT_COVARIANCE_ACCUMULATOR_UNIT_ASSERT_SVH
`define DISPLACEMENT_COVARIANCE_ACCUMULATOR_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define DCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define DCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/core/dca_pkg.sv
// ----------------------------------------------------------------------------
// dca_pkg
// Types and constants shared by the covariance accumulator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package dca_pkg;
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam int unsigned REG_ELEMENT_COUNT = 0;
  localparam int unsigned REG_FIRST_FRAME   = 1;
  localparam int unsigned REG_LAST_FRAME    = 2;

  localparam logic [19:0] FRAMES_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [23:0] target_coord;
    logic signed [23:0] reference_coord;
    logic               last_in_frame;
    logic [6:0]         row_index;
    logic [6:0]         col_index;
  } req_t;

  typedef struct packed {
    logic signed [63:0] entry_value;
    logic [1:0]         status;
  } rsp_t;

  // Divider handshake between the sequencer and the divide unit.
  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic [19:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/dca_stream_if.sv
// ----------------------------------------------------------------------------
// dca_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface dca_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dca_ram.sv
// ----------------------------------------------------------------------------
// dca_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module dca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4656
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/dca_div.sv
// ----------------------------------------------------------------------------
// dca_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module dca_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dca_pkg::div_req_t req,
  output dca_pkg::div_rsp_t      rsp
);
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [19:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic [64:0] trial;
  logic [63:0] mag;

  // Magnitude of the dividend for the unsigned core.
  assign mag = req.dividend[63] ? (~req.dividend + 64'd1) : req.dividend;
  assign shifted = {rem_r, quo_r[63]};
  assign trial = shifted - {45'd0, den_r};

  // One bit per step.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = 64'd0;
      quo_nxt  = mag;
      den_nxt  = req.divisor;
      neg_nxt  = req.dividend[63];
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~quo_r + 64'd1) : quo_r;
endmodule
`default_nettype wire

// File: rtl/core/displacement_covariance_accumulator_unit.sv
// After a sample's transfer the input is held not ready until the pass over its matrix
// entries is done (writing none when its frame is not accumulated); each matrix entry is a
// read-modify-write pipelined through the sum RAM's registered read. A valid read delivers
// its result after the 64-step divider, a rejected read in the cycle after its transfer.
// One item at a time. After reset and after a clear item, a pass over all
// MAX_DIM*(MAX_DIM+1)/2 entries zeroes the sum RAM and takes no item. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// displacement_covariance_accumulator_unit
// Accumulates the upper triangle of a displacement covariance matrix in RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module displacement_covariance_accumulator_unit #(
  parameter int MAX_DIM = 96
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dca_stream_if.sink                           in_ch,
  dca_stream_if.source                         out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [3:0]                      cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic      [31:0]                     cfg_prdata,
  output logic                                 cfg_pready
);
  localparam int TRI  = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int TW   = $clog2(TRI);
  localparam int DW   = $clog2(MAX_DIM);
  localparam int PW   = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MAC, S_DRAIN, S_RD_WAIT, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [6:0]  ecount_r;
  logic [19:0] first_r, last_r;
  logic [PW-1:0] pos_r;
  logic [19:0] frames_r;
  logic        wdone_r;
  logic [TW-1:0] clr_r;
  logic [DW-1:0] j_r;
  logic [PW-1:0] cur_r;
  logic signed [24:0] d_r;
  logic        acc_r;
  logic signed [49:0] prod_r;
  logic [63:0] res_r;
  logic [1:0]  stat_r;
  logic [PW-1:0] neff;
  logic [TW-1:0] row_base [MAX_DIM];

  // Row base offsets of the packed upper triangle.
  always_comb begin
    for (int r = 0; r < MAX_DIM; r++) begin
      row_base[r] = TW'(r * MAX_DIM - (r * (r - 1)) / 2);
    end
  end

  // Effective element count, clamped to 3..MAX_DIM.
  always_comb begin
    if (ecount_r < 7'd3) neff = PW'(3);
    else if (32'(ecount_r) > MAX_DIM) neff = PW'(MAX_DIM);
    else neff = PW'(ecount_r);
  end

  // Configuration port.
  assign cfg_pready = 1'b1;
  always_comb begin
    case (32'(cfg_paddr[3:2]))
      dca_pkg::REG_ELEMENT_COUNT: cfg_prdata = {25'd0, ecount_r};
      dca_pkg::REG_FIRST_FRAME:   cfg_prdata = {12'd0, first_r};
      dca_pkg::REG_LAST_FRAME:    cfg_prdata = {12'd0, last_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // Displacement RAM and sum RAM.
  logic          dwe;
  logic [DW-1:0] dwaddr, draddr;
  logic [24:0]   dwdata, drdata;
  logic          swe;
  logic [TW-1:0] swaddr, sraddr;
  logic [63:0]   swdata, srdata;

  dca_ram #(.WIDTH(25), .DEPTH(MAX_DIM)) u_disp (
    .clk, .we(dwe), .waddr(dwaddr), .wdata(dwdata), .raddr(draddr), .rdata(drdata)
  );
  dca_ram #(.WIDTH(64), .DEPTH(TRI)) u_sum (
    .clk, .we(swe), .waddr(swaddr), .wdata(swdata), .raddr(sraddr), .rdata(srdata)
  );

  dca_pkg::div_req_t dreq;
  dca_pkg::div_rsp_t drsp;
  dca_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  // Request decode.
  dca_pkg::req_t rq;
  assign rq = in_ch.data;
  assign in_ch.ready = (state_r == S_IDLE);
  logic acc_in;
  assign acc_in = in_ch.valid && in_ch.ready;

  logic [PW-1:0] pos_cl;
  assign pos_cl = (pos_r >= neff) ? neff - PW'(1) : pos_r;
  logic signed [24:0] d_in;
  assign d_in = 25'(rq.target_coord) - 25'(rq.reference_coord);

  // MAC pipeline: j_r read issued; stage 1 has displacement data and issues
  // the sum read; stage 2 holds product and sum data and writes.
  // The pipeline visits distinct entries, so no forwarding is needed.
  logic signed [64:0] sum_ext;
  assign sum_ext = 65'($signed(srdata)) + 65'(prod_r);
  logic [63:0] sat;
  always_comb begin
    if (sum_ext[64] != sum_ext[63]) sat = sum_ext[64] ? 64'h8000000000000000
                                                      : 64'h7FFFFFFFFFFFFFFF;
    else sat = sum_ext[63:0];
  end

  logic [DW-1:0] jd_r;   // index whose displacement arrives this cycle
  logic          v1_r;
  logic          v2_r;
  logic [TW-1:0] a1_r, a2_r;
  logic signed [24:0] dj_h;

  // The last element uses the register copy, earlier ones the RAM.
  assign dj_h = (32'(jd_r) == 32'(cur_r)) ? d_r : $signed(drdata);

  always_comb begin
    dwe    = 1'b0;
    dwaddr = DW'(pos_cl);
    dwdata = d_in;
    draddr = j_r;
    swe    = 1'b0;
    swaddr = a2_r;
    swdata = sat;
    sraddr = a1_r;
    dreq.start    = 1'b0;
    dreq.dividend = $signed(srdata);
    dreq.divisor  = frames_r;
    if (state_r == S_CLEAR) begin
      swe    = 1'b1;
      swaddr = clr_r;
      swdata = 64'd0;
    end else if (state_r == S_IDLE && acc_in && rq.req_type == dca_pkg::REQ_SAMPLE
                 && !wdone_r) begin
      dwe = 1'b1;
    end else if (state_r == S_IDLE) begin
      sraddr = row_base[DW'(rq.row_index)] + TW'(rq.col_index - rq.row_index);
    end
    if (v2_r) swe = 1'b1;
    if (state_r == S_RD_WAIT) dreq.start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      ecount_r <= 7'd96;
      first_r  <= 20'd0;
      last_r   <= 20'hFFFFF;
      pos_r    <= '0;
      frames_r <= '0;
      wdone_r  <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (32'(cfg_paddr[3:2]))
          dca_pkg::REG_ELEMENT_COUNT: ecount_r <= cfg_pwdata[6:0];
          dca_pkg::REG_FIRST_FRAME:   first_r  <= cfg_pwdata[19:0];
          dca_pkg::REG_LAST_FRAME:    last_r   <= cfg_pwdata[19:0];
          default: ;
        endcase
      end
      v2_r <= v1_r;
      a2_r <= a1_r;
      prod_r <= 50'(dj_h) * 50'(d_r);
      v1_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + TW'(1);
          if (32'(clr_r) == TRI - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (acc_in) begin
            case (rq.req_type)
              dca_pkg::REQ_SAMPLE: begin
                if (!wdone_r) begin
                  d_r   <= d_in;
                  cur_r <= pos_cl;
                  j_r   <= '0;
                  acc_r <= (frames_r + 20'd1 >= first_r) || frames_r == dca_pkg::FRAMES_MAX;
                  state_r <= S_MAC;
                  if (rq.last_in_frame || pos_cl >= neff - PW'(1)) begin
                    if (frames_r + 20'd1 == last_r && frames_r != dca_pkg::FRAMES_MAX)
                      wdone_r <= 1'b1;
                    if (frames_r != dca_pkg::FRAMES_MAX) frames_r <= frames_r + 20'd1;
                    pos_r <= '0;
                  end else begin
                    pos_r <= pos_cl + PW'(1);
                  end
                end
              end
              dca_pkg::REQ_READ: begin
                if (rq.row_index > rq.col_index || 32'(rq.col_index) >= 32'(neff)) begin
                  stat_r <= dca_pkg::ST_RANGE;
                  res_r <= '0;
                  state_r <= S_OUT;
                  out_ch.valid <= 1'b1;
                end else if (frames_r == 20'd0) begin
                  stat_r <= dca_pkg::ST_NO_FRAME;
                  res_r <= '0;
                  state_r <= S_OUT;
                  out_ch.valid <= 1'b1;
                end else begin
                  stat_r <= dca_pkg::ST_OK;
                  state_r <= S_RD_WAIT;
                end
              end
              dca_pkg::REQ_CLEAR: begin
                pos_r <= '0;
                frames_r <= '0;
                wdone_r <= 1'b0;
                clr_r <= '0;
                state_r <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_MAC: begin
          // Issue one read pair per cycle for entries (j, cur).
          jd_r <= j_r;
          a1_r <= row_base[j_r] + TW'(cur_r) - TW'(j_r);
          v1_r <= acc_r;
          if (32'(j_r) == 32'(cur_r)) state_r <= S_DRAIN;
          else j_r <= j_r + DW'(1);
        end
        S_DRAIN: begin
          // The last write leaves the pipeline in the cycle in which stage 1 is seen empty.
          if (!v1_r) state_r <= S_IDLE;
        end
        S_RD_WAIT: state_r <= S_DIV;
        S_DIV: begin
          if (drsp.done) begin
            res_r <= drsp.quotient;
            out_ch.valid <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.data.entry_value = res_r;
  assign out_ch.data.status      = stat_r;
endmodule
`default_nettype wire

// File: rtl/core/dca_checker.sv
// ----------------------------------------------------------------------------
// dca_checker
// Port-level checks on the covariance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "displacement_covariance_accumulator_unit_assert.svh"
module dca_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_value,
  input wire logic [1:0]  out_status
);
  // An output waiting for transfer holds its payload.
  `DCA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(out_value), "output dropped")
  // A failed read reports zero.
  `DCA_ASSERT_IMP(a_zero, clk, rst_n, out_valid && out_status != dca_pkg::ST_OK,
                  out_value == 64'd0, "nonzero value on error")
  // No input is taken while a result waits.
  `DCA_ASSERT_IMP(a_one, clk, rst_n, out_valid, !in_ready, "input taken with result pending")
  // Status is a defined code.
  `DCA_ASSERT_IMP(a_stat, clk, rst_n, out_valid, out_status <= dca_pkg::ST_RANGE, "bad status")
endmodule

bind displacement_covariance_accumulator_unit dca_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_value(out_ch.data.entry_value), .out_status(out_ch.data.status)
);
`default_nettype wire
